@@ hdl/ddd_pkg.sv @@
// Shared types, constants and calendar functions for the date difference block.
package ddd_pkg;

  localparam int DIFF_BITS = 22;
  localparam int LEAP_BITS = 16;

  // Divisibility by 25 for 16-bit years: multiply by the modular inverse of 25
  // and compare against the largest multiple-of-25 quotient.
  localparam logic [LEAP_BITS-1:0] INV25 = 16'd23593;
  localparam logic [LEAP_BITS-1:0] LIM25 = 16'd2621;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic load;
    logic swap;
    logic step;
    logic finish;
  } ddd_cmd_t;

  typedef struct packed {
    logic dates_ok;
    logic cur_after_tgt;
    logic at_target;
    logic out_full;
  } ddd_stat_t;

  function automatic logic is_leap(input logic [LEAP_BITS-1:0] y);
    logic [LEAP_BITS-1:0] p;
    logic                 div25;
    p     = LEAP_BITS'(y * INV25);
    div25 = (p <= LIM25);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  // Zero for a month code that means nothing, so any day fails the check.
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(input logic [3:0] m, input logic [4:0] d,
                                   input logic leap);
    return (d != 5'd0) && (d <= days_in_month(m, leap));
  endfunction

endpackage

@@ hdl/ddd_in_if.sv @@
// Input channel: two dates and the end-day flag.
interface ddd_in_if #(parameter int YEAR_BITS = 12) ();
  logic                 valid;
  logic                 ready;
  logic [YEAR_BITS-1:0] start_year;
  logic [3:0]           start_month;
  logic [4:0]           start_day;
  logic [YEAR_BITS-1:0] end_year;
  logic [3:0]           end_month;
  logic [4:0]           end_day;
  logic                 include_end_day;

  modport source (output valid, start_year, start_month, start_day,
                  end_year, end_month, end_day, include_end_day, input ready);
  modport sink (input valid, start_year, start_month, start_day,
                end_year, end_month, end_day, include_end_day, output ready);
endinterface

@@ hdl/ddd_out_if.sv @@
// Result channel: signed day count and bad-date flag.
interface ddd_out_if ();
  logic               valid;
  logic               ready;
  logic signed [21:0] day_difference;
  logic               bad_date;

  modport source (output valid, day_difference, bad_date, input ready);
  modport sink (input valid, day_difference, bad_date, output ready);
endinterface

@@ hdl/ddd_datapath.sv @@
// Datapath: date registers, day walker, step counter and output register.
module ddd_datapath #(
  parameter int YEAR_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  ddd_in_if.sink              in_ch,
  ddd_out_if.source           out_ch,
  input  ddd_pkg::ddd_cmd_t   cmd,
  output ddd_pkg::ddd_stat_t  stat
);
  import ddd_pkg::*;

  logic [YEAR_BITS-1:0] cy_r, cy_nxt, ty_r, ty_nxt;
  logic [3:0]           cm_r, cm_nxt, tm_r, tm_nxt;
  logic [4:0]           cd_r, cd_nxt, td_r, td_nxt;
  logic                 incl_r, incl_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIFF_BITS-1:0] cnt_r, cnt_nxt;
  logic [DIFF_BITS-1:0] diff_r, diff_nxt;
  logic                 bad_r, bad_nxt;
  logic                 ovalid_r, ovalid_nxt;

  logic                 leap_cur, leap_tgt;
  logic [4:0]           len_cur;
  logic [DIFF_BITS-1:0] mag;

  assign leap_cur = is_leap(LEAP_BITS'(cy_r));
  assign leap_tgt = is_leap(LEAP_BITS'(ty_r));
  assign len_cur  = days_in_month(cm_r, leap_cur);

  assign stat.dates_ok      = date_ok(cm_r, cd_r, leap_cur) && date_ok(tm_r, td_r, leap_tgt);
  assign stat.cur_after_tgt = {cy_r, cm_r, cd_r} > {ty_r, tm_r, td_r};
  assign stat.at_target     = {cy_r, cm_r, cd_r} == {ty_r, tm_r, td_r};
  assign stat.out_full      = ovalid_r && !out_ch.ready;

  assign mag = cnt_r + DIFF_BITS'(incl_r);

  always_comb begin
    cy_nxt     = cy_r;
    cm_nxt     = cm_r;
    cd_nxt     = cd_r;
    ty_nxt     = ty_r;
    tm_nxt     = tm_r;
    td_nxt     = td_r;
    incl_nxt   = incl_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    diff_nxt   = diff_r;
    bad_nxt    = bad_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    if (cmd.load) begin
      cy_nxt   = in_ch.start_year;
      cm_nxt   = in_ch.start_month;
      cd_nxt   = in_ch.start_day;
      ty_nxt   = in_ch.end_year;
      tm_nxt   = in_ch.end_month;
      td_nxt   = in_ch.end_day;
      incl_nxt = in_ch.include_end_day;
      neg_nxt  = 1'b0;
      cnt_nxt  = '0;
    end
    if (cmd.swap) begin
      // walk from the earlier date; remember to flip the sign
      cy_nxt  = ty_r;
      cm_nxt  = tm_r;
      cd_nxt  = td_r;
      ty_nxt  = cy_r;
      tm_nxt  = cm_r;
      td_nxt  = cd_r;
      neg_nxt = 1'b1;
    end
    if (cmd.step) begin
      cnt_nxt = cnt_r + DIFF_BITS'(1);
      if (cd_r >= len_cur) begin
        cd_nxt = 5'd1;
        if (cm_r == MONTH_DEC) begin
          cm_nxt = 4'd1;
          cy_nxt = cy_r + YEAR_BITS'(1);
        end else begin
          cm_nxt = cm_r + 4'd1;
        end
      end else begin
        cd_nxt = cd_r + 5'd1;
      end
    end
    if (cmd.finish) begin
      ovalid_nxt = 1'b1;
      // the date registers hold bad dates only on the bad-date path
      bad_nxt    = !stat.dates_ok;
      if (!stat.dates_ok) begin
        diff_nxt = '0;
      end else if (neg_r) begin
        diff_nxt = DIFF_BITS'(-mag);
      end else begin
        diff_nxt = mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    cy_r   <= cy_nxt;
    cm_r   <= cm_nxt;
    cd_r   <= cd_nxt;
    ty_r   <= ty_nxt;
    tm_r   <= tm_nxt;
    td_r   <= td_nxt;
    incl_r <= incl_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    diff_r <= diff_nxt;
    bad_r  <= bad_nxt;
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.day_difference = diff_r;
  assign out_ch.bad_date       = bad_r;

endmodule

@@ hdl/ddd_ctrl.sv @@
// Controller: sequences load, check, walk and hand-off of one word at a time.
module ddd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ddd_pkg::ddd_stat_t  stat,
  output ddd_pkg::ddd_cmd_t   cmd
);
  import ddd_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.dates_ok) begin
          state_nxt = S_DONE;
        end else begin
          cmd.swap  = stat.cur_after_tgt;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.at_target) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        // hold until the output register frees up
        if (!stat.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/date_difference_in_days.sv @@
// Gregorian date difference: takes two dates and an include-end-day flag per word and
// returns the signed day count from the first date to the second, or bad_date with a
// zero count when a day, month or day-of-month is out of range. The earlier date is
// walked forward one day per clock until it meets the later one; the finished result
// then waits in the done state until the output register frees up.
// One word is in flight at a time; the next word is taken while the previous result
// still waits in the output register.
module date_difference_in_days #(
  parameter int YEAR_BITS = 12
) (
  input logic       clk,
  input logic       rst_n,
  ddd_in_if.sink    in_ch,
  ddd_out_if.source out_ch
);
  import ddd_pkg::*;

  ddd_cmd_t  cmd;
  ddd_stat_t stat;
  logic      ready;

  assign in_ch.ready = ready;

  ddd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ddd_datapath #(
    .YEAR_BITS (YEAR_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule
